/* hw/rtl/mm_pkg.sv */
// Shared constants and types for the 4x4 fixed-point matrix multiplier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mm_pkg;

  // Default matrix dimension.
  localparam int unsigned DIM_DEFAULT = 4;

  // Field widths of the transfers.
  localparam int unsigned IDX_W = 2;
  localparam int unsigned VAL_W = 32;

  // Q16.16 format.
  localparam int unsigned FRAC_BITS = 16;

  // Saturation limits of the result.
  localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

  // Sequencer states.
  localparam logic SEQ_IDLE = 1'b0;
  localparam logic SEQ_RUN  = 1'b1;

  // Control that travels with a token through the cell chain.
  typedef struct packed {
    logic valid;
    logic last;
  } mm_ctrl_t;

  // Store write broadcast to all cells.
  typedef struct packed {
    logic             en;
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;
  } mm_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/mm_if.sv */
// Valid/ready channel interfaces for the matrix multiplier.
// Depends on mm_pkg for the field widths.
`default_nettype none

interface mm_in_if import mm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;
  logic [VAL_W-1:0] left_value;
  logic [VAL_W-1:0] right_value;
  logic             load_last;

  modport source (
    output valid, row_index, col_index, left_value, right_value, load_last,
    input  ready
  );
  modport sink (
    input  valid, row_index, col_index, left_value, right_value, load_last,
    output ready
  );
endinterface

interface mm_out_if import mm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_col;
  logic [VAL_W-1:0] product_value;
  logic             saturated;
  logic             out_last;

  modport source (
    output valid, out_row, out_col, product_value, saturated, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_row, out_col, product_value, saturated, out_last,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/matrix_multiply_4x4.sv */
// The first product element is presented once its token has gone through the
// chain and the output register; the DIM*DIM elements then follow one per
// cycle while the output side keeps taking them. Loads are taken one per
// cycle while no burst is running; after a last load, input stays blocked
// until the token stream through the chain of DIM two-stage cells drains.
// Reset is asynchronous and active low; it clears control only, stores stay
// undefined until written.
`default_nettype none

module matrix_multiply_4x4 import mm_pkg::*; #(
  parameter int unsigned DIM = DIM_DEFAULT
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  mm_in_if.sink   in_i,
  mm_out_if.source out_o
);

  localparam int unsigned IW    = $clog2(DIM);
  localparam int unsigned ACC_W = 2 * VAL_W + $clog2(DIM);
  localparam int unsigned SH_W  = ACC_W - FRAC_BITS;

  // The whole chain moves in lockstep; it advances whenever the output
  // register is empty or being drained in this cycle.
  logic adv;

  logic in_xfer;
  logic in_range;
  mm_wr_t wr;
  logic [IW-1:0] wr_row;
  logic [IW-1:0] wr_col;

  // Sequencer that issues one token per product element, row-major.
  logic          state_q, state_d;
  logic [IW-1:0] r_q, r_d;
  logic [IW-1:0] c_q, c_d;
  logic          seq_last;

  // Chain taps: index k is the input of cell k, index DIM the chain output.
  mm_ctrl_t                ctrl_c [DIM+1];
  logic [IW-1:0]           row_c  [DIM+1];
  logic [IW-1:0]           col_c  [DIM+1];
  logic signed [ACC_W-1:0] acc_c  [DIM+1];
  logic [DIM-1:0]          busy_c;

  // Output stage.
  logic [SH_W-1:0]        shifted;
  logic [SH_W-VAL_W:0]    high_bits;
  logic                   sat;
  logic [VAL_W-1:0]       value;
  logic                   out_valid_q;
  logic [IDX_W-1:0]       out_row_q;
  logic [IDX_W-1:0]       out_col_q;
  logic [VAL_W-1:0]       out_value_q;
  logic                   out_sat_q;
  logic                   out_last_q;

  assign adv = !out_valid_q || out_o.ready;

  // Loads are taken only when no token is in flight, so a write never
  // changes an element that a pending product still has to read.
  assign in_i.ready = (state_q == SEQ_IDLE) && !(|busy_c);
  assign in_xfer    = in_i.valid && in_i.ready;

  // Element pairs outside the matrix are dropped; load_last still counts.
  assign in_range = (32'(in_i.row_index) < DIM) && (32'(in_i.col_index) < DIM);
  assign wr_row   = IW'(in_i.row_index);
  assign wr_col   = IW'(in_i.col_index);
  assign wr.en    = in_xfer && in_range;
  assign wr.left  = in_i.left_value;
  assign wr.right = in_i.right_value;

  assign seq_last = (r_q == IW'(DIM - 1)) && (c_q == IW'(DIM - 1));

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (in_xfer && in_i.load_last) begin
          state_d = SEQ_RUN;
          r_d     = '0;
          c_d     = '0;
        end
      end
      SEQ_RUN: begin
        if (adv) begin
          if (seq_last) begin
            state_d = SEQ_IDLE;
          end else if (c_q == IW'(DIM - 1)) begin
            c_d = '0;
            r_d = r_q + IW'(1);
          end else begin
            c_d = c_q + IW'(1);
          end
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      r_q     <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
    end
  end

  // Each token starts with a zero sum; cell k adds left(r,k) * right(k,c).
  assign ctrl_c[0].valid = (state_q == SEQ_RUN);
  assign ctrl_c[0].last  = seq_last;
  assign row_c[0]        = r_q;
  assign col_c[0]        = c_q;
  assign acc_c[0]        = '0;

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    mm_cell #(
      .DIM     (DIM),
      .CellIdx (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .wr_i     (wr),
      .wr_row_i (wr_row),
      .wr_col_i (wr_col),
      .ctrl_i   (ctrl_c[k]),
      .row_i    (row_c[k]),
      .col_i    (col_c[k]),
      .acc_i    (acc_c[k]),
      .ctrl_o   (ctrl_c[k+1]),
      .row_o    (row_c[k+1]),
      .col_o    (col_c[k+1]),
      .acc_o    (acc_c[k+1]),
      .busy_o   (busy_c[k])
    );
  end

  // The exact sum is floored by the arithmetic shift, then clipped to the
  // 32-bit range: it fits only if all bits from bit 31 upward agree.
  assign shifted   = acc_c[DIM][ACC_W-1:FRAC_BITS];
  assign high_bits = shifted[SH_W-1:VAL_W-1];
  assign sat       = !((&high_bits) || !(|high_bits));
  assign value     = sat ? (shifted[SH_W-1] ? SAT_MIN : SAT_MAX)
                         : shifted[VAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctrl_c[DIM].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_row_q   <= IDX_W'(row_c[DIM]);
      out_col_q   <= IDX_W'(col_c[DIM]);
      out_value_q <= value;
      out_sat_q   <= sat;
      out_last_q  <= ctrl_c[DIM].last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_row       = out_row_q;
  assign out_o.out_col       = out_col_q;
  assign out_o.product_value = out_value_q;
  assign out_o.saturated     = out_sat_q;
  assign out_o.out_last      = out_last_q;

endmodule

`default_nettype wire

/* hw/rtl/mm_cell.sv */
// One cell of the multiply-accumulate chain: holds column CellIdx of the
// left matrix and row CellIdx of the right matrix. Depends on mm_pkg.
`default_nettype none

module mm_cell import mm_pkg::*; #(
  parameter int unsigned DIM     = DIM_DEFAULT,
  parameter int unsigned CellIdx = 0,
  localparam int unsigned IW     = $clog2(DIM),
  localparam int unsigned ACC_W  = 2 * VAL_W + $clog2(DIM)
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     adv_i,
  input  mm_wr_t                  wr_i,
  input  wire  [IW-1:0]           wr_row_i,
  input  wire  [IW-1:0]           wr_col_i,
  input  mm_ctrl_t                ctrl_i,
  input  wire  [IW-1:0]           row_i,
  input  wire  [IW-1:0]           col_i,
  input  wire  signed [ACC_W-1:0] acc_i,
  output mm_ctrl_t                ctrl_o,
  output logic [IW-1:0]           row_o,
  output logic [IW-1:0]           col_o,
  output logic signed [ACC_W-1:0] acc_o,
  output logic                    busy_o
);

  logic [VAL_W-1:0] left_mem  [DIM];
  logic [VAL_W-1:0] right_mem [DIM];

  logic signed [VAL_W-1:0]   a_op;
  logic signed [VAL_W-1:0]   b_op;
  logic signed [2*VAL_W-1:0] prod_d;

  mm_ctrl_t                  ctrl_a_q;
  logic [IW-1:0]             row_a_q;
  logic [IW-1:0]             col_a_q;
  logic signed [ACC_W-1:0]   acc_a_q;
  logic signed [2*VAL_W-1:0] prod_a_q;

  mm_ctrl_t                  ctrl_b_q;
  logic [IW-1:0]             row_b_q;
  logic [IW-1:0]             col_b_q;
  logic signed [ACC_W-1:0]   acc_b_q;

  // Left element (r, c) lives in cell c at slot r; right element (r, c)
  // lives in cell r at slot c.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_col_i == IW'(CellIdx))) begin
      left_mem[wr_row_i] <= wr_i.left;
    end
    if (wr_i.en && (wr_row_i == IW'(CellIdx))) begin
      right_mem[wr_col_i] <= wr_i.right;
    end
  end

  assign a_op   = left_mem[row_i];
  assign b_op   = right_mem[col_i];
  assign prod_d = a_op * b_op;

  // Stage A: the multiply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
    end else if (adv_i) begin
      ctrl_a_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      row_a_q  <= row_i;
      col_a_q  <= col_i;
      acc_a_q  <= acc_i;
      prod_a_q <= prod_d;
    end
  end

  // Stage B: the accumulate, handed to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_b_q <= '0;
    end else if (adv_i) begin
      ctrl_b_q <= ctrl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      row_b_q <= row_a_q;
      col_b_q <= col_a_q;
      acc_b_q <= acc_a_q + ACC_W'(prod_a_q);
    end
  end

  assign ctrl_o = ctrl_b_q;
  assign row_o  = row_b_q;
  assign col_o  = col_b_q;
  assign acc_o  = acc_b_q;
  assign busy_o = ctrl_a_q.valid | ctrl_b_q.valid;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply_4x4: Q16.16 product bursts are predicted
// in a scoreboard class and checked element by element. Depends on mm_pkg and the
// mm_in_if / mm_out_if channel interfaces.

// Tracks the two stored matrices as they are loaded and keeps the queue of product
// elements that each last load makes the block emit.
class product_board;
  typedef struct packed {
    logic [mm_pkg::IDX_W-1:0] row;
    logic [mm_pkg::IDX_W-1:0] col;
    logic [mm_pkg::VAL_W-1:0] value;
    logic                     sat;
    logic                     last;
  } product_t;

  localparam int N = mm_pkg::DIM_DEFAULT;

  logic signed [mm_pkg::VAL_W-1:0] left_mat [N][N];
  logic signed [mm_pkg::VAL_W-1:0] right_mat [N][N];
  product_t awaiting [$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
    foreach (left_mat[r, c]) begin
      left_mat[r][c]  = '0;
      right_mat[r][c] = '0;
    end
  endfunction

  function int unsigned pending();
    return awaiting.size();
  endfunction

  // Stores the element pair, and on a last load queues the whole product burst.
  function void note_load(logic [1:0] row, logic [1:0] col, logic [31:0] lv,
                          logic [31:0] rv, logic last);
    left_mat[row][col]  = lv;
    right_mat[row][col] = rv;
    if (last) begin
      predict_burst();
    end
  endfunction

  // Exact dot product, floor shift by the fraction bits, then clip to 32 bits.
  function void predict_burst();
    logic signed [65:0] acc;
    logic signed [63:0] term;
    longint floor_sum;
    product_t p;
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c < N; c++) begin
        acc = '0;
        for (int k = 0; k < N; k++) begin
          term = 64'(left_mat[r][k]) * 64'(right_mat[k][c]);
          acc  = acc + 66'(term);
        end
        floor_sum = longint'(acc >>> mm_pkg::FRAC_BITS);
        p.row  = r[1:0];
        p.col  = c[1:0];
        p.sat  = 1'b0;
        p.last = (r == N - 1) && (c == N - 1);
        if (floor_sum > 64'sd2147483647) begin
          p.value = mm_pkg::SAT_MAX;
          p.sat   = 1'b1;
        end else if (floor_sum < -64'sd2147483648) begin
          p.value = mm_pkg::SAT_MIN;
          p.sat   = 1'b1;
        end else begin
          p.value = floor_sum[31:0];
        end
        awaiting.push_back(p);
      end
    end
  endfunction

  function void compare_field(string name, longint expected, longint actual);
    if (expected != actual) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, expected, actual);
    end
  endfunction

  function void check_product(logic [1:0] row, logic [1:0] col, logic [31:0] value,
                              logic sat, logic last);
    product_t p;
    if (awaiting.size() == 0) begin
      mismatches++;
      $error("product (%0d,%0d) = %0d arrived with nothing outstanding",
             row, col, $signed(value));
      return;
    end
    p = awaiting.pop_front();
    compare_field("out_row", longint'(p.row), longint'(row));
    compare_field("out_col", longint'(p.col), longint'(col));
    compare_field("product_value", longint'($signed(p.value)), longint'($signed(value)));
    compare_field("saturated", longint'(p.sat), longint'(sat));
    compare_field("out_last", longint'(p.last), longint'(last));
  endfunction
endclass

module tb_top;
  import mm_pkg::*;

  localparam int ITEM_TARGET    = 480;
  // Cycles in which neither side completes a transfer before the run is declared hung.
  // The longest legal quiet stretch is the deliberate receiver hold plus a burst latency.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 400;
  // First element leaves once its token has passed the chain; the other DIM*DIM-1 follow.
  localparam int DRAIN_CYCLES   = 2 * DIM_DEFAULT + 1 + DIM_DEFAULT * DIM_DEFAULT + 30;
  localparam int PAUSE_SET      = 12;
  localparam int CALM_FROM      = 220;
  localparam int CALM_TO        = 320;

  // Value mixes for one load set.
  typedef enum int {STYLE_SMALL, STYLE_MEDIUM, STYLE_WILD} value_style_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  mm_in_if  in_bus ();
  mm_out_if out_bus ();

  matrix_multiply_4x4 u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  product_board board = new();

  int unsigned items_sent;
  int unsigned products_taken;
  int unsigned quiet_cycles;
  // While set, neither side idles: this gives a stretch of back-to-back transfers.
  bit calm;

  always #2 clk_i = ~clk_i;

  // Reset is held low from the start and released on a rising edge, once.
  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Transfer monitor. Both channels are sampled at the rising edge, where every
  // testbench drive and every register of the block still holds its old value.
  // A load transfer feeds the scoreboard; a product transfer is checked against it.
  // The watchdog counts edges at which neither channel completes a transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        board.note_load(in_bus.row_index, in_bus.col_index, in_bus.left_value,
                        in_bus.right_value, in_bus.load_last);
      end
      if (out_bus.valid && out_bus.ready) begin
        products_taken++;
        board.check_product(out_bus.out_row, out_bus.out_col, out_bus.product_value,
                            out_bus.saturated, out_bus.out_last);
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Product receiver. It drops ready at random with a chance of about 27 percent,
  // never during the calm stretch, and once holds ready low for a long stretch so that
  // the block backs up and has to refuse further loads.
  int unsigned hold_left;
  bit          hold_done;

  initial begin
    out_bus.ready <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && products_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (calm) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= 27);
      end
    end
  end

  // Offers one load and returns at the edge where it is transferred. Idle cycles are
  // inserted only before valid is raised, so an offered load is never withdrawn.
  task automatic offer_load(input logic [1:0] row, input logic [1:0] col,
                            input logic [31:0] lv, input logic [31:0] rv,
                            input logic last);
    calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.row_index   <= row;
    in_bus.col_index   <= col;
    in_bus.left_value  <= lv;
    in_bus.right_value <= rv;
    in_bus.load_last   <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_element(value_style_e style);
    logic [31:0] v;
    case (style)
      // Within +/-8.0: sums never clip, so rounding toward minus infinity shows.
      STYLE_SMALL:  v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      // Within +/-128.0: sums sit near the clipping boundary.
      STYLE_MEDIUM: v = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      default: begin
        case ($urandom_range(0, 5))
          0, 1, 2: v = $urandom();
          3:       v = SAT_MIN;
          4:       v = SAT_MAX;
          default: v = ($urandom_range(0, 1) != 0) ? 32'h0000_0001 : 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin : stimulus
    logic [3:0]   pos;
    int unsigned  order [16];
    int unsigned  set_count;
    int unsigned  shape;
    int unsigned  count;
    int unsigned  j;
    int unsigned  tmp;
    value_style_e style;

    in_bus.valid       <= 1'b0;
    in_bus.row_index   <= '0;
    in_bus.col_index   <= '0;
    in_bus.left_value  <= '0;
    in_bus.right_value <= '0;
    in_bus.load_last   <= 1'b0;
    items_sent     = 0;
    products_taken = 0;
    quiet_cycles   = 0;
    calm           = 1'b0;
    set_count      = 0;

    do @(posedge clk_i); while (!rst_ni);

    // Directed part. Every position is loaded before the first last load, so no
    // burst ever reads an entry that was never written.
    // Both matrices full of the most negative value: every sum is 2^64, which
    // clips to the positive limit.
    for (int p = 0; p < 16; p++) begin
      pos = 4'(p);
      offer_load(pos[3:2], pos[1:0], SAT_MIN, SAT_MIN, p == 15);
    end
    // Row 0 to the largest value: row 0 of the product goes strongly negative and
    // clips to the negative limit.
    for (int c = 0; c < 4; c++) begin
      offer_load(2'd0, c[1:0], SAT_MAX, SAT_MAX, c == 3);
    end
    // Row 1 to minus one LSB and plus one LSB: row 1 of the product gets small exact sums that do not clip.
    for (int c = 0; c < 4; c++) begin
      offer_load(2'd1, c[1:0], 32'hFFFF_FFFF, 32'h0000_0001, c == 3);
    end

    // Random part, built from load sets: whole matrices in shuffled order, partial
    // updates, loads that end no burst, and single last loads back to back.
    while (items_sent < ITEM_TARGET) begin
      set_count++;
      if (set_count == PAUSE_SET) begin
        // Sender pause: nothing is offered until every predicted product is in.
        in_bus.valid <= 1'b0;
        @(posedge clk_i);
        while (board.pending() != 0) @(posedge clk_i);
      end
      style = value_style_e'($urandom_range(0, 2));
      shape = $urandom_range(0, 99);
      if (shape < 40) begin
        foreach (order[i]) order[i] = i;
        for (int i = 15; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < 16; i++) begin
          pos = 4'(order[i]);
          offer_load(pos[3:2], pos[1:0], pick_element(style), pick_element(style), i == 15);
        end
      end else if (shape < 75) begin
        count = $urandom_range(1, 6);
        for (int i = 0; i < count; i++) begin
          pos = 4'($urandom_range(0, 15));
          offer_load(pos[3:2], pos[1:0], pick_element(style), pick_element(style),
                     i == count - 1);
        end
      end else if (shape < 90) begin
        count = $urandom_range(1, 3);
        for (int i = 0; i < count; i++) begin
          pos = 4'($urandom_range(0, 15));
          offer_load(pos[3:2], pos[1:0], pick_element(style), pick_element(style), 1'b0);
        end
      end else begin
        pos = 4'($urandom_range(0, 15));
        offer_load(pos[3:2], pos[1:0], pick_element(style), pick_element(style), 1'b1);
      end
    end

    // Wind down: let the monitor record the final transfer, wait for every product,
    // then watch a little longer for anything the block should not send.
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/mm_pkg.sv
hw/rtl/mm_if.sv
hw/rtl/mm_cell.sv
hw/rtl/matrix_multiply_4x4.sv
verif/tb_top.sv
